[hw/rtl/mwe_rd_pkg.sv]
// shared types and constants of the microwire eeprom word reader
package mwe_rd_pkg;

  localparam int DATA_BITS = 16;
  localparam int ADDR_LEN_W = 4;

  // preamble low bit, preamble high bit, then read opcode 10
  localparam logic [2:0] READ_OPCODE = 3'b110;
  localparam logic [ADDR_LEN_W-1:0] ADDR_LEN_RESET = 4'd8;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic [ADDR_LEN_W-1:0] address_bits;
    logic [DATA_BITS-1:0]  read_word;
    logic                  done_res;
    logic                  drive_di;
    logic                  chip_select;
  } res_t;

endpackage

[hw/rtl/microwire_eeprom_word_reader.sv]
// microwire serial eeprom word reader, master side, with address length learning
//
//  channel  dir  tdata (lowest bit up)                         tuser / tlast
//  s_*      in   offset[11:0], sampled_do[12], zero[15:13]     tuser: op
//  m_*      out  chip_select[0], drive_di[1], read_word[17:2], tlast: done_res
//                address_bits[21:18], zero[23:22]
//
//  for every input word, state and result are worked out from the state registers
//  and the word in one pass and land in the result register, or in the skid register
//  a result register plus a one-word skid register part the two sides, so an
//  input word is taken while a result waits; s_tready drops only when both hold
//  rst is synchronous, clears control state and sets the address length to eight
//  each input word yields exactly one result word
module microwire_eeprom_word_reader
  import mwe_rd_pkg::*;
#(
  parameter int MAX_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // offset[11:0], sampled_do[12], zero pad
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // chip_select, drive_di, read_word, address_bits, pad
  output logic        m_tlast    // done_res
);

  // frame: zero, one, one, zero, address, data phase; top index is the first bit
  localparam int FRAME_W = MAX_ADDR_BITS + DATA_BITS + 4;
  localparam int IDX_W = $clog2(FRAME_W);

  // serial state
  logic                  active;
  logic                  active_next;
  logic [IDX_W-1:0]      bit_index;
  logic [IDX_W-1:0]      bit_index_next;
  logic [FRAME_W-1:0]    frame_shift;
  logic [FRAME_W-1:0]    frame_shift_next;
  logic [DATA_BITS-1:0]  data_shift;
  logic [DATA_BITS-1:0]  data_shift_next;
  logic [ADDR_LEN_W-1:0] addr_length;
  logic [ADDR_LEN_W-1:0] addr_length_next;

  // result register and skid register
  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;

  // input word fields
  op_t             op;
  logic [11:0]     offset;
  logic            sampled_do;

  logic            accept;
  logic            take;
  res_t            res;

  // working values
  logic [ADDR_LEN_W-1:0] len;
  logic [IDX_W-1:0]      shrink;
  logic [IDX_W-1:0]      idx_work;

  assign op         = op_t'(s_tuser);
  assign offset     = s_tdata[11:0];
  assign sampled_do = s_tdata[12];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;

  always_comb begin
    active_next      = active;
    bit_index_next   = bit_index;
    frame_shift_next = frame_shift;
    data_shift_next  = data_shift;
    addr_length_next = addr_length;
    res              = '0;
    len              = (addr_length > ADDR_LEN_W'(MAX_ADDR_BITS)) ?
                       ADDR_LEN_W'(MAX_ADDR_BITS) : addr_length;
    shrink           = bit_index - IDX_W'(DATA_BITS);
    idx_work         = bit_index;

    case (op)
      OP_START: begin
        // abandon any read in progress and load a fresh frame
        frame_shift_next = ((FRAME_W'(READ_OPCODE) << len) | FRAME_W'(offset))
                           << DATA_BITS;
        bit_index_next   = IDX_W'(len) + IDX_W'(DATA_BITS + 3);
        data_shift_next  = '0;
        active_next      = 1'b1;
      end
      OP_TICK: begin
        if (active) begin
          // eeprom drives its dummy zero once it has the whole address
          if (!sampled_do && (bit_index > IDX_W'(DATA_BITS))) begin
            addr_length_next = (IDX_W'(addr_length) > shrink) ?
                               addr_length - ADDR_LEN_W'(shrink) : ADDR_LEN_W'(1);
            idx_work         = IDX_W'(DATA_BITS);
          end
          data_shift_next = {data_shift[DATA_BITS-2:0], sampled_do};
          if (idx_work == '0) begin
            active_next   = 1'b0;
            res.done_res  = 1'b1;
            res.read_word = data_shift_next;
          end else begin
            bit_index_next = idx_work - IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    res.chip_select  = active_next;
    res.drive_di     = active_next && frame_shift_next[bit_index_next];
    res.address_bits = addr_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      bit_index   <= '0;
      data_shift  <= '0;
      addr_length <= ADDR_LEN_RESET;
    end else if (accept) begin
      active      <= active_next;
      bit_index   <= bit_index_next;
      data_shift  <= data_shift_next;
      addr_length <= addr_length_next;
    end
  end

  // frame bits are only looked at while a read is active
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_shift <= frame_shift_next;
    end
  end

  // result register with one word of skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
          if (accept) begin
            out_data <= res;
          end
        end
      end else if (accept) begin
        if (!out_valid) begin
          out_data  <= res;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_data.done_res;
  assign m_tdata  = {2'b00, out_data.address_bits, out_data.read_word,
                     out_data.drive_di, out_data.chip_select};

  // a finished read always releases chip select
  a_done_drops_cs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.chip_select)
    else $error("done word with chip select still high");

  // di is held low while chip select is low
  a_di_needs_cs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_di |-> out_data.chip_select)
    else $error("di driven with chip select low");

  // the skid register fills only behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without result word");

  // the learned address length never grows and never reaches zero
  a_addr_len_shrinks: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (addr_length <= $past(addr_length)) && (addr_length != '0))
    else $error("address length grew or reached zero");

endmodule
